// ===== rtl/fu8h_pkg.sv =====
// Shared types, constants and helper functions for the folded UTF-8 FNV-1a hash block.
package fu8h_pkg;

    localparam logic [31:0] FNV_BASIS   = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME   = 32'h0100_0193;
    localparam logic [20:0] REPLACEMENT = 21'h00_fffd;
    localparam logic [20:0] MAX_CP      = 21'h10_ffff;
    localparam logic [20:0] SURR_LO     = 21'h00_d800;
    localparam logic [20:0] SURR_HI     = 21'h00_dfff;
    localparam logic [20:0] MIN_CP_2    = 21'h00_0080;
    localparam logic [20:0] MIN_CP_3    = 21'h00_0800;
    localparam logic [20:0] MIN_CP_4    = 21'h01_0000;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ENC,
        ST_EMIT
    } state_t;

    // Smart quotes and dashes fold to ASCII, and capitals fold to lower case.
    function automatic logic [20:0] fold_cp(input logic [20:0] cp);
        logic [20:0] res;
        res = cp;
        if (cp == 21'h2018 || cp == 21'h2019) begin
            res = 21'h27;
        end else if (cp == 21'h201c || cp == 21'h201d) begin
            res = 21'h22;
        end else if (cp == 21'h2013 || cp == 21'h2014) begin
            res = 21'h2d;
        end else if (cp >= 21'h41 && cp <= 21'h5a) begin
            res = cp + 21'd32;
        end
        return res;
    endfunction

    // Index of the last UTF-8 byte that encodes the code point (length minus one).
    function automatic logic [1:0] enc_last(input logic [20:0] cp);
        logic [1:0] res;
        if (cp < MIN_CP_2) begin
            res = 2'd0;
        end else if (cp < MIN_CP_3) begin
            res = 2'd1;
        end else if (cp < MIN_CP_4) begin
            res = 2'd2;
        end else begin
            res = 2'd3;
        end
        return res;
    endfunction

    // One byte of the UTF-8 encoding of the code point, chosen by its index.
    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [7:0] res;
        res = 8'h00;
        unique case (enc_last(cp))
            2'd0: res = {1'b0, cp[6:0]};
            2'd1: begin
                case (idx)
                    2'd0:    res = {3'b110, cp[10:6]};
                    default: res = {2'b10, cp[5:0]};
                endcase
            end
            2'd2: begin
                case (idx)
                    2'd0:    res = {4'b1110, cp[15:12]};
                    2'd1:    res = {2'b10, cp[11:6]};
                    default: res = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    res = {5'b11110, cp[20:18]};
                    2'd1:    res = {2'b10, cp[17:12]};
                    2'd2:    res = {2'b10, cp[11:6]};
                    default: res = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return res;
    endfunction

    // One FNV-1a round: xor in the byte, then multiply by the prime modulo 2^32.
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

// ===== rtl/folded_utf8_fnv1a_hash.sv =====
// Folded UTF-8 FNV-1a-32 name hash: decoder, folding, re-encoder and shared hash round.
//
//  channel | direction | tdata fields (low bit up) | meaning
//  s_      | in        | name_byte[7:0]            | next byte of the name, zero ends it
//  m_      | out       | hash_out[31:0]            | hash of the whole name
//
// A byte is taken in the idle state and decoded in the following cycle. Every UTF-8 byte
// that is then hashed goes through the single FNV round unit, and each replacement
// flushed by a broken sequence is hashed there too, after which the breaking byte is
// decoded again.
// A terminator waits in the emit state while the output register is still full.
// Reset (aresetn low, synchronous) restarts the hash at the offset basis and
// closes any open sequence. s_tready is high only in the idle state.
module folded_utf8_fnv1a_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] name_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_out
);

    fu8h_pkg::state_t state_reg, state_next;

    logic [31:0] hash_reg, hash_next;
    logic [1:0]  pend_reg, pend_next;
    logic [1:0]  taken_reg, taken_next;
    logic [20:0] part_reg, part_next;
    logic [20:0] cp_reg, cp_next;
    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  flush_reg, flush_next;
    logic [7:0]  byte_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg;

    logic        in_fire;
    logic        out_free;
    logic        is_cont;
    logic [20:0] cont_part;
    logic [1:0]  cont_taken;
    logic        cont_done;
    logic [20:0] min_cp;
    logic        cp_bad;
    logic [1:0]  last_idx;
    logic        enc_done;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Continuation byte gathering and the validity check of a finished sequence.
    always_comb begin
        is_cont    = (byte_reg[7:6] == 2'b10);
        cont_part  = {part_reg[14:0], byte_reg[5:0]};
        cont_taken = taken_reg + 2'd1;
        cont_done  = (cont_taken >= pend_reg);
        case (pend_reg)
            2'd1:    min_cp = fu8h_pkg::MIN_CP_2;
            2'd2:    min_cp = fu8h_pkg::MIN_CP_3;
            default: min_cp = fu8h_pkg::MIN_CP_4;
        endcase
        cp_bad = (cont_part < min_cp)
            || (cont_part >= fu8h_pkg::SURR_LO && cont_part <= fu8h_pkg::SURR_HI)
            || (cont_part > fu8h_pkg::MAX_CP);
        last_idx = fu8h_pkg::enc_last(cp_reg);
        enc_done = (idx_reg == last_idx);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fu8h_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = fu8h_pkg::ST_DECODE;
                end
            end
            fu8h_pkg::ST_DECODE: begin
                if (pend_reg != 2'd0) begin
                    if (!is_cont || cont_done) begin
                        state_next = fu8h_pkg::ST_ENC;
                    end else begin
                        state_next = fu8h_pkg::ST_IDLE;
                    end
                end else if (byte_reg == 8'h00) begin
                    state_next = fu8h_pkg::ST_EMIT;
                end else if (byte_reg[7] == 1'b0 || byte_reg[7:6] == 2'b10
                             || byte_reg[7:3] == 5'b11111) begin
                    state_next = fu8h_pkg::ST_ENC;
                end else begin
                    state_next = fu8h_pkg::ST_IDLE;
                end
            end
            fu8h_pkg::ST_ENC: begin
                if (enc_done) begin
                    if (flush_reg == 2'd1) begin
                        state_next = fu8h_pkg::ST_DECODE;
                    end else if (flush_reg == 2'd0) begin
                        state_next = fu8h_pkg::ST_IDLE;
                    end
                end
            end
            fu8h_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = fu8h_pkg::ST_IDLE;
                end
            end
            default: state_next = fu8h_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready = (state_reg == fu8h_pkg::ST_IDLE);
    end

    // Datapath next values.
    always_comb begin
        hash_next     = hash_reg;
        pend_next     = pend_reg;
        taken_next    = taken_reg;
        part_next     = part_reg;
        cp_next       = cp_reg;
        idx_next      = idx_reg;
        flush_next    = flush_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            fu8h_pkg::ST_DECODE: begin
                if (pend_reg != 2'd0) begin
                    if (is_cont) begin
                        part_next  = cont_part;
                        taken_next = cont_taken;
                        if (cont_done) begin
                            cp_next    = cp_bad ? fu8h_pkg::REPLACEMENT
                                                : fu8h_pkg::fold_cp(cont_part);
                            pend_next  = 2'd0;
                            taken_next = 2'd0;
                            part_next  = '0;
                        end
                    end else begin
                        // Broken sequence: flush a replacement for the lead and for
                        // each continuation taken, then decode this byte again.
                        flush_next = taken_reg + 2'd1;
                        cp_next    = fu8h_pkg::REPLACEMENT;
                        pend_next  = 2'd0;
                        taken_next = 2'd0;
                        part_next  = '0;
                    end
                end else if (byte_reg[7] == 1'b0) begin
                    cp_next = fu8h_pkg::fold_cp({13'd0, byte_reg});
                end else if (byte_reg[7:5] == 3'b110) begin
                    pend_next  = 2'd1;
                    taken_next = 2'd0;
                    part_next  = {16'd0, byte_reg[4:0]};
                end else if (byte_reg[7:4] == 4'b1110) begin
                    pend_next  = 2'd2;
                    taken_next = 2'd0;
                    part_next  = {17'd0, byte_reg[3:0]};
                end else if (byte_reg[7:3] == 5'b11110) begin
                    pend_next  = 2'd3;
                    taken_next = 2'd0;
                    part_next  = {18'd0, byte_reg[2:0]};
                end else begin
                    cp_next = fu8h_pkg::REPLACEMENT;
                end
            end
            fu8h_pkg::ST_ENC: begin
                hash_next = fu8h_pkg::fnv_step(hash_reg, fu8h_pkg::enc_byte(cp_reg, idx_reg));
                if (enc_done) begin
                    idx_next = 2'd0;
                    if (flush_reg != 2'd0) begin
                        flush_next = flush_reg - 2'd1;
                    end
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            fu8h_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    hash_next     = fu8h_pkg::FNV_BASIS;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fu8h_pkg::ST_IDLE;
            hash_reg     <= fu8h_pkg::FNV_BASIS;
            pend_reg     <= 2'd0;
            taken_reg    <= 2'd0;
            part_reg     <= '0;
            idx_reg      <= 2'd0;
            flush_reg    <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hash_reg     <= hash_next;
            pend_reg     <= pend_next;
            taken_reg    <= taken_next;
            part_reg     <= part_next;
            idx_reg      <= idx_next;
            flush_reg    <= flush_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cp_reg <= cp_next;
        if (in_fire) begin
            byte_reg <= s_tdata;
        end
        if (state_reg == fu8h_pkg::ST_EMIT && out_free) begin
            m_tdata_reg <= hash_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // An accepted byte is always decoded in the following cycle.
    a_fire_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> state_reg == fu8h_pkg::ST_DECODE)
        else $error("accepted byte was not decoded next");

    // The encoder byte index never runs past the code point's length.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fu8h_pkg::ST_ENC |-> idx_reg <= last_idx)
        else $error("encoder index beyond code point length");

    // A flush only runs once the broken sequence has been closed.
    a_flush_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg != 2'd0 |-> pend_reg == 2'd0 && state_reg != fu8h_pkg::ST_IDLE)
        else $error("flush pending with an open sequence or while idle");

    // Emitting a result presents it and restarts the hash at the basis.
    a_emit_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fu8h_pkg::ST_EMIT && out_free
        |=> m_tvalid && hash_reg == fu8h_pkg::FNV_BASIS)
        else $error("result not presented or hash not restarted");
`endif

endmodule
